[hdl/gha_pkg.sv]
// gha_pkg: shared types and constants of the generational handle allocator
// used by gha_ctrl, gha_dp and generational_handle_allocator; no dependencies
`default_nettype none

package gha_pkg;

    localparam int HANDLE_W    = 32;
    localparam int INDEX_W     = 24;
    localparam int GEN_FIELD_W = 8;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STACK,
        ST_SLOT,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic cap;
        logic stack_rd;
        logic slot_rd;
        logic exec;
    } dp_cmd_t;

endpackage

`default_nettype wire

[hdl/gha_ctrl.sv]
// gha_ctrl: sequencing state machine of the handle allocator
// depends on gha_pkg; drives gha_dp through a dp_cmd_t struct
`default_nettype none

module gha_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output gha_pkg::dp_cmd_t     dp_cmd
);
    import gha_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_STACK;
                end
            end
            ST_STACK: state_next = ST_SLOT;
            ST_SLOT:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy            = 1'b1;
        dp_cmd.cap      = 1'b0;
        dp_cmd.stack_rd = 1'b0;
        dp_cmd.slot_rd  = 1'b0;
        dp_cmd.exec     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                dp_cmd.cap = start;
            end
            ST_STACK: dp_cmd.stack_rd = 1'b1;
            ST_SLOT:  dp_cmd.slot_rd  = 1'b1;
            ST_EXEC:  dp_cmd.exec     = 1'b1;
            default:  busy            = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[hdl/gha_dp.sv]
// gha_dp: slot table, free stack, counters and result registers
// depends on gha_pkg; sequenced by gha_ctrl
`default_nettype none

module gha_dp #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gha_pkg::dp_cmd_t                   dp_cmd,
    input  wire logic [gha_pkg::CMD_W-1:0]          command,
    input  wire logic [gha_pkg::HANDLE_W-1:0]       handle_in,
    output logic      [gha_pkg::HANDLE_W-1:0]       handle_out,
    output logic      [gha_pkg::STAT_W-1:0]         status,
    output logic                                    done
);
    import gha_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // slot entry: live mark above generation
    logic [GEN_BITS:0]  slot_mem [SLOT_COUNT];
    logic [IDX_W-1:0]   stack_mem [SLOT_COUNT];

    logic [CMD_W-1:0]       cmd_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [IDX_W-1:0]       stack_q_reg;
    logic [GEN_BITS:0]      slot_q_reg;
    logic [CNT_W-1:0]       free_depth_reg;
    logic [CNT_W-1:0]       free_depth_next;
    logic [CNT_W-1:0]       slots_used_reg;
    logic [CNT_W-1:0]       slots_used_next;
    logic [HANDLE_W-1:0]    handle_out_reg;
    logic [HANDLE_W-1:0]    handle_out_next;
    logic [STAT_W-1:0]      status_reg;
    logic [STAT_W-1:0]      status_next;
    logic                   done_reg;

    logic [CNT_W-1:0]       depth_m1;
    logic [INDEX_W-1:0]     h_idx;
    logic [GEN_FIELD_W-1:0] h_gen;
    logic [IDX_W-1:0]       slot_raddr;
    logic                   h_live;
    logic                   slot_we;
    logic [IDX_W-1:0]       slot_waddr;
    logic [GEN_BITS:0]      slot_wdata;
    logic                   stack_we;

    assign depth_m1 = free_depth_reg - CNT_W'(1);
    assign h_idx    = handle_reg[INDEX_W-1:0];
    assign h_gen    = handle_reg[HANDLE_W-1:INDEX_W];

    // popped slot on create, handle's slot otherwise
    assign slot_raddr = (cmd_reg == CMD_CREATE) ? stack_q_reg : h_idx[IDX_W-1:0];

    assign h_live = (h_idx < INDEX_W'(slots_used_reg)) && slot_q_reg[GEN_BITS]
                    && (GEN_FIELD_W'(slot_q_reg[GEN_BITS-1:0]) == h_gen);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.cap)
        begin
            cmd_reg    <= command;
            handle_reg <= handle_in;
        end
        if (dp_cmd.stack_rd)
        begin
            stack_q_reg <= stack_mem[depth_m1[IDX_W-1:0]];
        end
        if (stack_we)
        begin
            stack_mem[free_depth_reg[IDX_W-1:0]] <= h_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.slot_rd)
        begin
            slot_q_reg <= slot_mem[slot_raddr];
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

    always_comb
    begin
        slot_we         = 1'b0;
        slot_waddr      = slot_raddr;
        slot_wdata      = slot_q_reg;
        stack_we        = 1'b0;
        free_depth_next = free_depth_reg;
        slots_used_next = slots_used_reg;
        handle_out_next = '0;
        status_next     = STAT_INVALID;
        case (cmd_reg)
            CMD_CREATE:
            begin
                if (free_depth_reg != '0)
                begin
                    free_depth_next = depth_m1;
                    slot_we         = 1'b1;
                    slot_waddr      = stack_q_reg;
                    slot_wdata      = {1'b1, slot_q_reg[GEN_BITS-1:0]};
                    handle_out_next = {GEN_FIELD_W'(slot_q_reg[GEN_BITS-1:0]),
                                       INDEX_W'(stack_q_reg)};
                    status_next     = STAT_OK;
                end
                else if (slots_used_reg < CNT_W'(SLOT_COUNT))
                begin
                    slots_used_next = slots_used_reg + CNT_W'(1);
                    slot_we         = 1'b1;
                    slot_waddr      = slots_used_reg[IDX_W-1:0];
                    slot_wdata      = {1'b1, {GEN_BITS{1'b0}}};
                    handle_out_next = HANDLE_W'(slots_used_reg);
                    status_next     = STAT_OK;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            CMD_DESTROY:
            begin
                if (h_live)
                begin
                    slot_we     = 1'b1;
                    slot_waddr  = h_idx[IDX_W-1:0];
                    slot_wdata  = {1'b0, slot_q_reg[GEN_BITS-1:0] + GEN_BITS'(1)};
                    status_next = STAT_OK;
                    if (free_depth_reg < CNT_W'(SLOT_COUNT))
                    begin
                        stack_we        = 1'b1;
                        free_depth_next = free_depth_reg + CNT_W'(1);
                    end
                end
            end
            CMD_CHECK:
            begin
                status_next = h_live ? STAT_OK : STAT_INVALID;
            end
            default:
            begin
                status_next = STAT_INVALID;
            end
        endcase
        if (!dp_cmd.exec)
        begin
            slot_we         = 1'b0;
            stack_we        = 1'b0;
            free_depth_next = free_depth_reg;
            slots_used_next = slots_used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            slots_used_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            free_depth_reg <= free_depth_next;
            slots_used_reg <= slots_used_next;
            done_reg       <= dp_cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            handle_out_reg <= handle_out_next;
            status_reg     <= status_next;
        end
    end

    assign handle_out = handle_out_reg;
    assign status     = status_reg;
    assign done       = done_reg;

endmodule

`default_nettype wire

[hdl/generational_handle_allocator.sv]
// generational_handle_allocator: top level, joins gha_ctrl and gha_dp
// depends on gha_pkg, gha_ctrl, gha_dp
//
// A transaction is taken when start is high and busy is low; each one gives
// exactly one result, shown on handle_out and status for one cycle with done
// high. The receiver cannot stall it. A transaction runs through accept, free
// stack read, slot table read, then update and result, in that order, as on
// create the slot table read uses the entry popped from the free stack. A new
// transaction may be started in the cycle done is high. No clearing pass after
// reset.
`default_nettype none

module generational_handle_allocator #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [gha_pkg::CMD_W-1:0]      command,
    input  wire logic [gha_pkg::HANDLE_W-1:0]   handle_in,
    output logic      [gha_pkg::HANDLE_W-1:0]   handle_out,
    output logic      [gha_pkg::STAT_W-1:0]     status,
    output logic                                done
);
    import gha_pkg::*;

    dp_cmd_t dp_cmd;

    gha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .dp_cmd (dp_cmd)
    );

    gha_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .command    (command),
        .handle_in  (handle_in),
        .handle_out (handle_out),
        .status     (status),
        .done       (done)
    );

endmodule

`default_nettype wire
